FILE: hw/rtl/epsnfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epsnfa_pkg;

    // fixed field widths of the item and configuration ports
    localparam int MODE_W      = 3;
    localparam int STATE_IDX_W = 4;
    localparam int SYM_IDX_W   = 6;
    localparam int MASK_W      = 16;
    localparam int ALPHA_W     = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam int NUM_STATES_DEF  = 16;
    localparam int NUM_SYMBOLS_DEF = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_TRANS = 3'd0,
        MODE_LOAD_EPS   = 3'd1,
        MODE_START      = 3'd2,
        MODE_SYMBOL     = 3'd3,
        MODE_END        = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE   = 2'd0,
        CFG_ACCEPT_MASK   = 2'd1,
        CFG_ALPHABET_MASK = 2'd2
    } t_cfg_reg;

endpackage

`default_nettype wire

FILE: hw/rtl/epsilon_nfa_recognizer.sv
`timescale 1ns / 1ps
`default_nettype none

// loads, end string, unused modes, starts outside the state range and symbols that die on
//   the alphabet test or meet a dead string: result valid the cycle after the transfer
// other symbols: table reads of every state's row, then (unless the next set is empty)
//   closure passes over all epsilon rows, one epsilon row a cycle, then the write state posts
// start string: the closure passes, then the write state posts; one item in flight at a time
// reset first clears both tables, walking every transition-table address
module epsilon_nfa_recognizer
    #(
    parameter int NUM_STATES  = epsnfa_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = epsnfa_pkg::NUM_SYMBOLS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // item input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [epsnfa_pkg::MODE_W-1:0]      i_mode,
    input  wire logic [epsnfa_pkg::STATE_IDX_W-1:0] i_state_index,
    input  wire logic [epsnfa_pkg::SYM_IDX_W-1:0]   i_symbol_index,
    input  wire logic [epsnfa_pkg::MASK_W-1:0]      i_next_mask,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_verdict_valid,
    output logic                                    o_accepted,
    output logic                                    o_dead,
    output logic      [epsnfa_pkg::MASK_W-1:0]      o_active_set,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [epsnfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [epsnfa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import epsnfa_pkg::*;

    localparam int STW    = $clog2(NUM_STATES);
    localparam int SYMW   = $clog2(NUM_SYMBOLS);
    localparam int AW     = STW + SYMW;
    localparam int TDEPTH = 1 << AW;
    localparam int NS     = NUM_STATES;

    localparam logic [STW-1:0] LAST_S   = STW'(NUM_STATES - 1);
    localparam logic [AW-1:0]  CLR_LAST = AW'(TDEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TSCAN,
        ST_ESCAN,
        ST_WRITE
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]          r_clr, n_clr;
    logic [STATE_IDX_W-1:0] r_start_state, n_start_state;
    logic [MASK_W-1:0]      r_accept_mask, n_accept_mask;
    logic [ALPHA_W-1:0]     r_alpha_mask, n_alpha_mask;
    logic [NS-1:0]          r_set, n_set;
    logic                   r_dead, n_dead;
    logic [NS-1:0]          r_next, n_next;
    logic [SYMW-1:0]        r_sym, n_sym;
    logic [STW-1:0]         r_scan, n_scan;
    logic                   r_issuing, n_issuing;
    logic                   r_rd_valid, n_rd_valid;
    logic [STW-1:0]         r_rd_idx, n_rd_idx;
    logic                   r_rd_last, n_rd_last;
    logic                   r_changed, n_changed;
    logic                   r_out_valid, n_out_valid;
    logic                   r_verdict, n_verdict;
    logic                   r_accepted, n_accepted;
    logic                   r_dead_out, n_dead_out;
    logic [MASK_W-1:0]      r_active, n_active;

    logic            t_we;
    logic [AW-1:0]   t_waddr;
    logic [NS-1:0]   t_wdata;
    logic [AW-1:0]   t_raddr;
    logic [NS-1:0]   t_rdata;
    logic            e_we;
    logic [STW-1:0]  e_waddr;
    logic [NS-1:0]   e_wdata;
    logic [STW-1:0]  e_raddr;
    logic [NS-1:0]   e_rdata;

    logic [63:0]     w_nm_ext;
    logic [NS-1:0]   w_load_mask;
    logic [63:0]     w_acc_ext;
    logic [NS-1:0]   w_acc_mask;
    logic [7:0]      w_st_ext;
    logic            w_st_ok;
    logic            w_sym_ok;
    logic            w_in_alpha;
    logic            w_start_ok;
    logic [NS-1:0]   w_start_set;
    logic            w_out_free;
    logic            w_in_accept;

    epsnfa_ram #(
        .WIDTH (NS),
        .DEPTH (TDEPTH)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    epsnfa_ram #(
        .WIDTH (NS),
        .DEPTH (NUM_STATES)
    ) u_eps_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    assign w_nm_ext    = 64'(i_next_mask);
    assign w_load_mask = w_nm_ext[NS-1:0];
    assign w_acc_ext   = 64'(r_accept_mask);
    assign w_acc_mask  = w_acc_ext[NS-1:0];
    assign w_st_ext    = 8'(i_state_index);
    assign w_st_ok     = 32'(i_state_index) < 32'(NUM_STATES);
    assign w_sym_ok    = 32'(i_symbol_index) < 32'(NUM_SYMBOLS);
    assign w_in_alpha  = w_sym_ok && r_alpha_mask[i_symbol_index];
    assign w_start_ok  = 32'(r_start_state) < 32'(NUM_STATES);
    assign w_start_set = {{(NS-1){1'b0}}, 1'b1} << r_start_state;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == ST_IDLE) && w_out_free);
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign t_raddr = {r_scan, r_sym};
    assign e_raddr = r_scan;

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_verdict_valid = r_verdict;
    assign o_accepted      = r_accepted;
    assign o_dead          = r_dead_out;
    assign o_active_set    = r_active;

    always_comb begin
        logic          emit;
        logic          verdict;
        logic          acc;
        logic [NS-1:0] nxt;
        logic [NS-1:0] grown;
        logic          chg;
        logic [63:0]   set_ext;

        n_state       = r_state;
        n_clr         = r_clr;
        n_start_state = r_start_state;
        n_accept_mask = r_accept_mask;
        n_alpha_mask  = r_alpha_mask;
        n_set         = r_set;
        n_dead        = r_dead;
        n_next        = r_next;
        n_sym         = r_sym;
        n_scan        = r_scan;
        n_issuing     = r_issuing;
        n_rd_valid    = 1'b0;
        n_rd_idx      = r_rd_idx;
        n_rd_last     = r_rd_last;
        n_changed     = r_changed;
        n_out_valid   = r_out_valid && i_out_stall;
        n_verdict     = r_verdict;
        n_accepted    = r_accepted;
        n_dead_out    = r_dead_out;
        n_active      = r_active;

        t_we    = 1'b0;
        t_waddr = {w_st_ext[STW-1:0], i_symbol_index[SYMW-1:0]};
        t_wdata = w_load_mask;
        e_we    = 1'b0;
        e_waddr = w_st_ext[STW-1:0];
        e_wdata = w_load_mask;

        emit    = 1'b0;
        verdict = 1'b0;
        acc     = 1'b0;
        nxt     = r_next;
        grown   = r_set;
        chg     = r_changed;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_STATE:   n_start_state = i_cfg_data[STATE_IDX_W-1:0];
                CFG_ACCEPT_MASK:   n_accept_mask = i_cfg_data[MASK_W-1:0];
                CFG_ALPHABET_MASK: n_alpha_mask  = i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end

        // one memory row read issued per cycle, data back in the following cycle
        if (r_issuing) begin
            n_rd_valid = 1'b1;
            n_rd_idx   = r_scan;
            n_rd_last  = (r_scan == LAST_S);
            if (r_scan == LAST_S) begin
                n_issuing = 1'b0;
            end else begin
                n_scan = r_scan + 1'b1;
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                t_we    = 1'b1;
                t_waddr = r_clr;
                t_wdata = '0;
                e_we    = (r_clr[STW-1:0] <= LAST_S) && (r_clr[AW-1:STW] == '0);
                e_waddr = r_clr[STW-1:0];
                e_wdata = '0;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_in_accept) begin
                    unique case (i_mode)
                        MODE_LOAD_TRANS: begin
                            t_we = w_st_ok && w_sym_ok;
                            emit = 1'b1;
                        end
                        MODE_LOAD_EPS: begin
                            e_we = w_st_ok;
                            emit = 1'b1;
                        end
                        MODE_START: begin
                            n_dead = 1'b0;
                            if (w_start_ok) begin
                                n_set     = w_start_set;
                                n_scan    = '0;
                                n_issuing = 1'b1;
                                n_changed = 1'b0;
                                n_state   = ST_ESCAN;
                            end else begin
                                n_set = '0;
                                emit  = 1'b1;
                            end
                        end
                        MODE_SYMBOL: begin
                            if (r_dead) begin
                                emit = 1'b1;
                            end else if (!w_in_alpha) begin
                                n_dead = 1'b1;
                                n_set  = '0;
                                emit   = 1'b1;
                            end else begin
                                n_sym     = i_symbol_index[SYMW-1:0];
                                n_next    = '0;
                                n_scan    = '0;
                                n_issuing = 1'b1;
                                n_state   = ST_TSCAN;
                            end
                        end
                        MODE_END: begin
                            emit    = 1'b1;
                            verdict = 1'b1;
                            acc     = !r_dead && ((r_set & w_acc_mask) != '0);
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            ST_TSCAN: begin
                if (r_rd_valid) begin
                    nxt    = r_next | (r_set[r_rd_idx] ? t_rdata : '0);
                    n_next = nxt;
                    if (r_rd_last) begin
                        if (nxt == '0) begin
                            n_dead  = 1'b1;
                            n_set   = '0;
                            n_state = ST_WRITE;
                        end else begin
                            n_set     = nxt;
                            n_scan    = '0;
                            n_issuing = 1'b1;
                            n_changed = 1'b0;
                            n_state   = ST_ESCAN;
                        end
                    end
                end
            end
            ST_ESCAN: begin
                // set grows in place; a pass that adds nothing ends the closure
                if (r_rd_valid) begin
                    grown     = r_set | (r_set[r_rd_idx] ? e_rdata : '0);
                    chg       = r_changed || (grown != r_set);
                    n_set     = grown;
                    n_changed = chg;
                    if (r_rd_last) begin
                        if (chg) begin
                            n_scan    = '0;
                            n_issuing = 1'b1;
                            n_changed = 1'b0;
                        end else begin
                            n_state = ST_WRITE;
                        end
                    end
                end
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        set_ext = 64'(n_set);
        if (emit) begin
            n_out_valid = 1'b1;
            n_verdict   = verdict;
            n_accepted  = acc;
            n_dead_out  = n_dead;
            n_active    = set_ext[MASK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr         <= '0;
            r_start_state <= '0;
            r_accept_mask <= '0;
            r_alpha_mask  <= '0;
            r_set         <= '0;
            r_dead        <= 1'b0;
            r_scan        <= '0;
            r_issuing     <= 1'b0;
            r_rd_valid    <= 1'b0;
            r_changed     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_start_state <= n_start_state;
            r_accept_mask <= n_accept_mask;
            r_alpha_mask  <= n_alpha_mask;
            r_set         <= n_set;
            r_dead        <= n_dead;
            r_scan        <= n_scan;
            r_issuing     <= n_issuing;
            r_rd_valid    <= n_rd_valid;
            r_changed     <= n_changed;
            r_out_valid   <= n_out_valid;
        end
        r_next     <= n_next;
        r_sym      <= n_sym;
        r_rd_idx   <= n_rd_idx;
        r_rd_last  <= n_rd_last;
        r_verdict  <= n_verdict;
        r_accepted <= n_accepted;
        r_dead_out <= n_dead_out;
        r_active   <= n_active;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/epsnfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module epsnfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import epsnfa_pkg::*;

    localparam int N_ST          = NUM_STATES_DEF;
    localparam int N_SYM         = NUM_SYMBOLS_DEF;
    localparam int IDLE_LIMIT    = 4000;   // covers the table clearing after reset too
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 400;
    localparam int ITEMS_PER_RUN = 200;
    localparam int RUNS          = 10;
    localparam int DIR_ROWS      = 33;

    localparam logic [MODE_W-1:0]    MODE_SPARE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    typedef struct packed {
        logic              verdict_valid;
        logic              accepted;
        logic              dead;
        logic [MASK_W-1:0] active_set;
    } nfa_out_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [MODE_W-1:0]     mode;
        logic [STATE_IDX_W-1:0] st;
        logic [SYM_IDX_W-1:0]  sym;
        logic [CFG_DATA_W-1:0] value;   // next mask of an item, or register data
        logic                  typed;
        nfa_out_t              want;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [MODE_W-1:0]      in_mode   = '0;
    logic [STATE_IDX_W-1:0] in_state  = '0;
    logic [SYM_IDX_W-1:0]   in_symbol = '0;
    logic [MASK_W-1:0]      in_mask   = '0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   verdict_valid;
    logic                   accepted;
    logic                   dead;
    logic [MASK_W-1:0]      active_set;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor copy of the automaton
    logic [MASK_W-1:0]      trans_tbl [N_ST*N_SYM] = '{default: '0};
    logic [MASK_W-1:0]      eps_tbl [N_ST]         = '{default: '0};
    logic [MASK_W-1:0]      cur_set    = '0;
    logic                   is_dead    = 1'b0;
    logic [STATE_IDX_W-1:0] start_reg  = '0;
    logic [MASK_W-1:0]      accept_reg = '0;
    logic [ALPHA_W-1:0]     alpha_reg  = '0;

    nfa_out_t nfa_out_q [$];
    dir_row_t dir_tab [DIR_ROWS];

    int  n_err        = 0;
    int  n_sent       = 0;
    int  idle_cycles  = 0;
    int  snd_idle_pct = 0;
    int  rcv_idle_pct = 0;
    bit  hold_req     = 1'b0;

    epsilon_nfa_recognizer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (in_mode),
        .i_state_index  (in_state),
        .i_symbol_index (in_symbol),
        .i_next_mask    (in_mask),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_verdict_valid(verdict_valid),
        .o_accepted     (accepted),
        .o_dead         (dead),
        .o_active_set   (active_set),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [MASK_W-1:0] eps_close(input logic [MASK_W-1:0] seed);
        logic [MASK_W-1:0] reach;
        logic [MASK_W-1:0] grown;
        reach = seed;
        for (int pass = 0; pass <= N_ST; pass++) begin
            grown = reach;
            for (int s = 0; s < N_ST; s++) begin
                if (reach[s]) grown |= eps_tbl[s];
            end
            if (grown == reach) break;
            reach = grown;
        end
        return reach;
    endfunction

    task automatic nfa_step(input logic [MODE_W-1:0] mode, input logic [STATE_IDX_W-1:0] st,
                            input logic [SYM_IDX_W-1:0] sym, input logic [MASK_W-1:0] nm,
                            output nfa_out_t res);
        logic [MASK_W-1:0] nxt;
        res = '0;
        case (mode)
            MODE_LOAD_TRANS: begin
                if (st < N_ST && sym < N_SYM) trans_tbl[st*N_SYM + sym] = nm;
            end
            MODE_LOAD_EPS: begin
                if (st < N_ST) eps_tbl[st] = nm;
            end
            MODE_START: begin
                is_dead = 1'b0;
                cur_set = (start_reg < N_ST) ? eps_close(16'd1 << start_reg) : '0;
            end
            MODE_SYMBOL: begin
                if (!is_dead) begin
                    nxt = '0;
                    if (alpha_reg[sym]) begin
                        for (int s = 0; s < N_ST; s++) begin
                            if (cur_set[s]) nxt |= trans_tbl[s*N_SYM + sym];
                        end
                    end
                    if (!alpha_reg[sym] || nxt == '0) begin
                        is_dead = 1'b1;
                        cur_set = '0;
                    end else begin
                        cur_set = eps_close(nxt);
                    end
                end
            end
            MODE_END: begin
                res.verdict_valid = 1'b1;
                res.accepted      = !is_dead && ((cur_set & accept_reg) != '0);
            end
            default: ;
        endcase
        res.dead       = is_dead;
        res.active_set = cur_set;
    endtask

    function automatic logic [MASK_W-1:0] rand_mask();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return 16'd1 << $urandom_range(15);
        if (pick < 75) return (16'd1 << $urandom_range(15)) | (16'd1 << $urandom_range(15));
        if (pick < 95) return 16'($urandom);
        return '0;
    endfunction

    function automatic logic [SYM_IDX_W-1:0] pick_sym(input logic [3:0][SYM_IDX_W-1:0] pool);
        if ($urandom_range(99) < 88) return pool[$urandom_range(3)];
        return 6'($urandom_range(63));
    endfunction

    task automatic wait_drain();
        while (nfa_out_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_START_STATE:   start_reg  = data[STATE_IDX_W-1:0];
            CFG_ACCEPT_MASK:   accept_reg = data[MASK_W-1:0];
            CFG_ALPHABET_MASK: alpha_reg  = data;
            default: ;
        endcase
    endtask

    // offer one item, hold it until the transfer, then advance the predictor
    task automatic offer_item(input logic [MODE_W-1:0] mode, input logic [STATE_IDX_W-1:0] st,
                              input logic [SYM_IDX_W-1:0] sym, input logic [MASK_W-1:0] nm,
                              output nfa_out_t res);
        // each cycle before the offer is idle with the sender's percentage
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_mode   <= mode;
        in_state  <= st;
        in_symbol <= sym;
        in_mask   <= nm;
        do @(posedge clk); while (!(in_valid && !in_stall));
        nfa_step(mode, st, sym, nm, res);
    endtask

    task automatic put_item(input logic [MODE_W-1:0] mode, input logic [STATE_IDX_W-1:0] st,
                            input logic [SYM_IDX_W-1:0] sym, input logic [MASK_W-1:0] nm);
        nfa_out_t res;
        offer_item(mode, st, sym, nm, res);
        nfa_out_q.push_back(res);
        n_sent++;
    endtask

    task automatic run_phase(input int p);
        logic [3:0][SYM_IDX_W-1:0] pool;
        logic [STATE_IDX_W-1:0]    start_v;
        logic [MASK_W-1:0]         acc_v;
        logic [ALPHA_W-1:0]        alpha_v;
        int                        target;
        int                        r;
        start_v = (p == 6) ? 4'd15 : (p == 7) ? 4'd0 : 4'($urandom_range(15));
        acc_v   = (p == 3) ? 16'h0000 : (p == 4) ? 16'hFFFF : (rand_mask() | rand_mask());
        alpha_v = $urandom_range(1) ? ({$urandom, $urandom} & {$urandom, $urandom}) : '0;
        for (int k = 0; k < 4; k++) begin
            pool[k] = 6'($urandom_range(63));
            alpha_v[pool[k]] = 1'b1;
        end
        if (p == 2) alpha_v = '0;
        if (p == 5) alpha_v = '1;
        write_reg(CFG_START_STATE, 64'(start_v));
        write_reg(CFG_ACCEPT_MASK, 64'(acc_v));
        write_reg(CFG_ALPHABET_MASK, alpha_v);
        cfg_valid <= 1'b0;
        if (p == 6) hold_req = 1'b1;
        // give the start state somewhere to go on the symbols in use
        for (int k = 0; k < 4; k++) put_item(MODE_LOAD_TRANS, start_v, pool[k], rand_mask());
        target = n_sent + ITEMS_PER_RUN;
        while (n_sent < target) begin
            r = $urandom_range(99);
            if (r < 6) begin
                put_item(3'($urandom_range(7)), 4'($urandom_range(15)), 6'($urandom_range(63)),
                         16'($urandom));
            end else if (r < 22) begin
                put_item(MODE_LOAD_TRANS, 4'($urandom_range(15)), pick_sym(pool), rand_mask());
            end else if (r < 30) begin
                put_item(MODE_LOAD_EPS, 4'($urandom_range(15)), 6'($urandom_range(63)),
                         ($urandom_range(2) == 0) ? 16'h0000 : rand_mask());
            end else begin
                // a string; now and then without its start or its end
                if ($urandom_range(9) != 0)
                    put_item(MODE_START, 4'($urandom_range(15)), 6'($urandom_range(63)),
                             16'($urandom));
                repeat ($urandom_range(1, 8))
                    put_item(MODE_SYMBOL, 4'($urandom_range(15)), pick_sym(pool),
                             16'($urandom));
                if ($urandom_range(9) != 0)
                    put_item(MODE_END, 4'($urandom_range(15)), 6'($urandom_range(63)),
                             16'($urandom));
            end
        end
        in_valid <= 1'b0;
        wait_drain();
    endtask

    task automatic check_field(input string what, input logic [MASK_W-1:0] want,
                               input logic [MASK_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            n_err++;
        end
    endtask

    // result side: random stall, with one long hold-off on request
    initial begin : rcv_blk
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin : mon_blk
        nfa_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (nfa_out_q.size() == 0) begin
                $display("%0t: result with none pending: expected nothing, got %b %b %b %h",
                         $time, verdict_valid, accepted, dead, active_set);
                n_err++;
            end else begin
                want = nfa_out_q.pop_front();
                check_field("verdict_valid", 16'(want.verdict_valid), 16'(verdict_valid));
                check_field("accepted", 16'(want.accepted), 16'(accepted));
                check_field("dead", 16'(want.dead), 16'(dead));
                check_field("active_set", want.active_set, active_set);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)
                && !(cfg_valid && cfg_ready)) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    initial begin : main_blk
        nfa_out_t res;
        bit       cfg_open;
        dir_tab = '{
            // reset settings: empty alphabet, start state 0, nothing accepts
            '{1'b0, CFG_START_STATE, MODE_SYMBOL, 4'd0, 6'd63, 64'd0, 1'b1,
              '{1'b0, 1'b0, 1'b1, 16'h0000}},
            '{1'b0, CFG_START_STATE, MODE_END, 4'd0, 6'd0, 64'd0, 1'b1,
              '{1'b1, 1'b0, 1'b1, 16'h0000}},
            '{1'b0, CFG_START_STATE, MODE_START, 4'd0, 6'd0, 64'd0, 1'b1,
              '{1'b0, 1'b0, 1'b0, 16'h0001}},
            '{1'b0, CFG_START_STATE, MODE_END, 4'd0, 6'd0, 64'd0, 1'b1,
              '{1'b1, 1'b0, 1'b0, 16'h0001}},
            '{1'b0, CFG_START_STATE, MODE_SPARE, 4'd15, 6'd63, 64'hFFFF, 1'b1,
              '{1'b0, 1'b0, 1'b0, 16'h0001}},
            '{1'b0, CFG_START_STATE, MODE_SYMBOL, 4'd0, 6'd0, 64'd0, 1'b1,
              '{1'b0, 1'b0, 1'b1, 16'h0000}},
            '{1'b0, CFG_START_STATE, MODE_SYMBOL, 4'd0, 6'd5, 64'd0, 1'b1,
              '{1'b0, 1'b0, 1'b1, 16'h0000}},
            '{1'b1, CFG_START_STATE, MODE_LOAD_TRANS, 4'd0, 6'd0, 64'd15, 1'b0, '0},
            '{1'b1, CFG_ACCEPT_MASK, MODE_LOAD_TRANS, 4'd0, 6'd0, 64'h8000, 1'b0, '0},
            '{1'b1, CFG_ALPHABET_MASK, MODE_LOAD_TRANS, 4'd0, 6'd0, '1, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_LOAD_TRANS, 4'd15, 6'd63, 64'hFFFF, 1'b1,
              '{1'b0, 1'b0, 1'b1, 16'h0000}},
            '{1'b0, CFG_START_STATE, MODE_LOAD_EPS, 4'd0, 6'd0, 64'h0002, 1'b1,
              '{1'b0, 1'b0, 1'b1, 16'h0000}},
            '{1'b0, CFG_START_STATE, MODE_LOAD_EPS, 4'd1, 6'd0, 64'h0004, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_LOAD_EPS, 4'd15, 6'd0, 64'h0001, 1'b0, '0},
            // epsilon chain from state 15 through 0 and 1 to 2
            '{1'b0, CFG_START_STATE, MODE_START, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_END, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_SYMBOL, 4'd0, 6'd63, 64'd0, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_LOAD_TRANS, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            // no state moves on symbol 0, so the string dies
            '{1'b0, CFG_START_STATE, MODE_SYMBOL, 4'd0, 6'd0, 64'd0, 1'b1,
              '{1'b0, 1'b0, 1'b1, 16'h0000}},
            '{1'b0, CFG_START_STATE, MODE_END, 4'd0, 6'd0, 64'd0, 1'b1,
              '{1'b1, 1'b0, 1'b1, 16'h0000}},
            '{1'b0, CFG_START_STATE, MODE_LOAD_TRANS, 4'd0, 6'd63, 64'h8000, 1'b0, '0},
            '{1'b1, CFG_START_STATE, MODE_LOAD_TRANS, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            '{1'b1, CFG_ACCEPT_MASK, MODE_LOAD_TRANS, 4'd0, 6'd0, 64'hFFFF, 1'b0, '0},
            '{1'b1, CFG_ALPHABET_MASK, MODE_LOAD_TRANS, 4'd0, 6'd0,
              64'h8000_0000_0000_0001, 1'b0, '0},
            '{1'b1, CFG_SPARE, MODE_LOAD_TRANS, 4'd0, 6'd0, '1, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_START, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            // symbol outside the alphabet
            '{1'b0, CFG_START_STATE, MODE_SYMBOL, 4'd0, 6'd31, 64'd0, 1'b1,
              '{1'b0, 1'b0, 1'b1, 16'h0000}},
            '{1'b0, CFG_START_STATE, MODE_START, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            // epsilon row changed in the middle of a string
            '{1'b0, CFG_START_STATE, MODE_LOAD_EPS, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_SYMBOL, 4'd0, 6'd63, 64'd0, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_END, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            '{1'b1, CFG_ACCEPT_MASK, MODE_LOAD_TRANS, 4'd0, 6'd0, 64'd0, 1'b0, '0},
            '{1'b0, CFG_START_STATE, MODE_END, 4'd0, 6'd0, 64'd0, 1'b0, '0}
        };
        cfg_open = 1'b0;
        snd_idle_pct = 8;
        rcv_idle_pct = 55;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].is_cfg) begin
                if (!cfg_open) begin
                    in_valid <= 1'b0;
                    wait_drain();
                end
                write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                offer_item(dir_tab[i].mode, dir_tab[i].st, dir_tab[i].sym,
                           dir_tab[i].value[MASK_W-1:0], res);
                nfa_out_q.push_back(dir_tab[i].typed ? dir_tab[i].want : res);
            end
        end
        in_valid <= 1'b0;
        wait_drain();

        for (int p = 0; p < RUNS; p++) begin
            if (p < 3) begin
                snd_idle_pct = 8;
                rcv_idle_pct = 55;
            end else if (p < 6) begin
                snd_idle_pct = 55;
                rcv_idle_pct = 8;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            run_phase(p);
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/epsnfa_pkg.sv
hw/rtl/epsnfa_ram.sv
hw/rtl/epsilon_nfa_recognizer.sv
tb/sv/tb_top.sv
